>>> rtl/core/ipv4_octet_range_acl_macros.svh
// assertion macros for the ipv4 octet range access list
`ifndef IPV4_OCTET_RANGE_ACL_MACROS_SVH
`define IPV4_OCTET_RANGE_ACL_MACROS_SVH

// same-cycle implication, checked out of reset
`define IORACL_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define IORACL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/ioracl_pkg.sv
// package: types, constants and request codes of the ipv4 octet range access list
`default_nettype none

package ioracl_pkg;

  localparam int unsigned TABLE_DEPTH  = 16;
  localparam int unsigned IDX_W        = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W        = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned RULE_INDEX_W = 4;
  localparam int unsigned OCTETS       = 4;

  localparam logic [1:0] REQ_LOOKUP = 2'd0;
  localparam logic [1:0] REQ_APPEND = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] address;
    logic [31:0] range_low;
    logic [31:0] range_high;
    logic [7:0]  type_byte;
  } req_t;

  typedef struct packed {
    logic                    hit;
    logic [RULE_INDEX_W-1:0] rule_index;
    logic [7:0]              matched_type;
    logic                    status;
  } rsp_t;

  typedef struct packed {
    logic [31:0] low;
    logic [31:0] high;
    logic [7:0]  type_byte;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

>>> rtl/core/ipv4_octet_range_acl.sv
// top level: first-match ipv4 octet range access list with a rule table in ram
//
//   channel   | ports                  | handshake
//   ----------+------------------------+--------------------------------------
//   request   | start, busy, req_i     | taken at a clock edge with start & !busy
//   result    | valid_o, rsp_o         | one cycle strobe, no back pressure
//
// append, clear and unused codes: result on the ports the cycle after the request edge,
//   busy never rises
// lookup: one cycle per rule scanned (one ram read each, compare on the next cycle),
//   result registered from the compare of the matching or last rule, which ends the scan
// busy stays high for the whole scan; the next request may come with the result
// reset empties the table at once; stored entries are only compared below the rule count
`default_nettype none

`include "ipv4_octet_range_acl_macros.svh"

module ipv4_octet_range_acl
  import ioracl_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic      busy,
  input  wire req_t req_i,
  output logic      valid_o,
  output rsp_t      rsp_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] rule_count_q, rule_count_d;
  logic [IDX_W-1:0] cmp_idx_q, cmp_idx_d;
  logic             valid_q, valid_d;
  rsp_t             rsp_q, rsp_d;

  logic             accept;
  logic             full;
  logic             last;
  logic             match;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [IDX_W-1:0] ram_raddr;
  entry_t           ram_wdata;
  entry_t           ram_rdata;
  logic [ENTRY_W-1:0] ram_rdata_raw;
  logic [31:0]      addr_q;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && (state_q == S_IDLE);
  assign full   = (rule_count_q == CNT_W'(TABLE_DEPTH));
  assign last   = (CNT_W'(cmp_idx_q) == rule_count_q - CNT_W'(1));

  assign ram_waddr = rule_count_q[IDX_W-1:0];
  assign ram_wdata = '{low: req_i.range_low, high: req_i.range_high,
                       type_byte: req_i.type_byte};
  assign ram_raddr = (state_q == S_SCAN) ? cmp_idx_q + IDX_W'(1) : '0;
  assign ram_rdata = entry_t'(ram_rdata_raw);

  ioracl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_rule_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );

  // address lies inside the rule's bounds on every octet
  always_comb begin
    logic [7:0] a_oct;
    logic [7:0] l_oct;
    logic [7:0] h_oct;
    match = 1'b1;
    for (int k = 0; k < OCTETS; k++) begin
      a_oct = addr_q[8*k +: 8];
      l_oct = ram_rdata.low[8*k +: 8];
      h_oct = ram_rdata.high[8*k +: 8];
      if ((l_oct > a_oct) || (a_oct > h_oct)) begin
        match = 1'b0;
      end
    end
  end

  // lookup address held for the scan
  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q <= req_i.address;
    end
  end

  always_comb begin
    state_d      = state_q;
    rule_count_d = rule_count_q;
    cmp_idx_d    = cmp_idx_q;
    valid_d      = 1'b0;
    rsp_d        = '0;
    ram_we       = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (req_i.req_type)
            REQ_LOOKUP: begin
              if (rule_count_q == '0) begin
                valid_d = 1'b1;
              end else begin
                state_d   = S_SCAN;
                cmp_idx_d = '0;
              end
            end
            REQ_APPEND: begin
              valid_d = 1'b1;
              if (full) begin
                rsp_d.status = 1'b1;
              end else begin
                ram_we           = 1'b1;
                rsp_d.rule_index = RULE_INDEX_W'(rule_count_q);
                rule_count_d     = rule_count_q + CNT_W'(1);
              end
            end
            REQ_CLEAR: begin
              valid_d      = 1'b1;
              rule_count_d = '0;
            end
            default: begin
              valid_d = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (match) begin
          valid_d            = 1'b1;
          rsp_d.hit          = 1'b1;
          rsp_d.rule_index   = RULE_INDEX_W'(cmp_idx_q);
          rsp_d.matched_type = ram_rdata.type_byte;
          state_d            = S_IDLE;
        end else if (last) begin
          valid_d = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmp_idx_d = cmp_idx_q + IDX_W'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      rule_count_q <= '0;
      cmp_idx_q    <= '0;
      valid_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      rule_count_q <= rule_count_d;
      cmp_idx_q    <= cmp_idx_d;
      valid_q      <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

  `IORACL_ASSERT_IMPL(a_count_bound, 1'b1, rule_count_q <= CNT_W'(TABLE_DEPTH), "rule count past depth")
  `IORACL_ASSERT_IMPL(a_scan_in_range, state_q == S_SCAN, CNT_W'(cmp_idx_q) < rule_count_q, "scan past last rule")
  `IORACL_ASSERT_NEXT(a_append_grows, accept && req_i.req_type == REQ_APPEND && !full, rule_count_q == $past(rule_count_q) + CNT_W'(1), "append lost")
  `IORACL_ASSERT_NEXT(a_request_progress, accept, valid_q || state_q == S_SCAN, "request dropped")
  `IORACL_ASSERT_IMPL(a_hit_ok_status, valid_q && rsp_q.hit, !rsp_q.status, "hit with error status")

endmodule

`default_nettype wire

>>> rtl/core/ioracl_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module ioracl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> tb/ipv4_octet_range_acl_tb.sv
// testbench for the ipv4 octet range access list: results checked against a predictor
`default_nettype none

module ipv4_octet_range_acl_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ioracl_pkg::*;

  localparam logic [1:0]  REQ_UNUSED  = 2'd3;
  localparam int unsigned TOTAL_ITEMS = 1100;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned TAIL_CYCLES = 24;
  localparam int unsigned MAX_PRINTS  = 100;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic valid_o;
  rsp_t rsp_o;

  logic [31:0] low_tab  [TABLE_DEPTH];
  logic [31:0] high_tab [TABLE_DEPTH];
  logic [7:0]  type_tab [TABLE_DEPTH];
  int unsigned rule_cnt   = 0;
  rsp_t        pending_rsp [$];
  int unsigned err_cnt    = 0;
  int unsigned sent_cnt   = 0;
  int unsigned burst_left = 0;
  int unsigned cycle_cnt  = 0;

  ipv4_octet_range_acl i_dut (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .req_i,
    .valid_o,
    .rsp_o
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic bit octets_match(logic [31:0] addr, logic [31:0] lo, logic [31:0] hi);
    for (int k = 0; k < OCTETS; k++) begin
      if (addr[8*k +: 8] < lo[8*k +: 8] || addr[8*k +: 8] > hi[8*k +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // updates the predicted table and returns the response for one request
  function automatic rsp_t acl_response(req_t r);
    rsp_t rsp;
    rsp = '0;
    case (r.req_type)
      REQ_LOOKUP: begin
        for (int i = 0; i < rule_cnt; i++) begin
          if (octets_match(r.address, low_tab[i], high_tab[i])) begin
            rsp.hit          = 1'b1;
            rsp.rule_index   = RULE_INDEX_W'(i);
            rsp.matched_type = type_tab[i];
            return rsp;
          end
        end
      end
      REQ_APPEND: begin
        if (rule_cnt >= TABLE_DEPTH) begin
          rsp.status = 1'b1;
        end else begin
          low_tab[rule_cnt]  = r.range_low;
          high_tab[rule_cnt] = r.range_high;
          type_tab[rule_cnt] = r.type_byte;
          rsp.rule_index     = RULE_INDEX_W'(rule_cnt);
          rule_cnt++;
        end
      end
      REQ_CLEAR: begin
        rule_cnt = 0;
      end
      default: ;
    endcase
    return rsp;
  endfunction

  task automatic report_mismatch(string msg);
    err_cnt++;
    if (err_cnt <= MAX_PRINTS) $display("%0t mismatch: %s", $time, msg);
  endtask

  always @(posedge clk_i) begin
    rsp_t exp_rsp;
    if (rst_ni && valid_o) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch($sformatf("result with no request pending: %p", rsp_o));
      end else begin
        exp_rsp = pending_rsp.pop_front();
        if (rsp_o.hit !== exp_rsp.hit)
          report_mismatch($sformatf("hit %b, expected %b", rsp_o.hit, exp_rsp.hit));
        if (rsp_o.rule_index !== exp_rsp.rule_index)
          report_mismatch($sformatf("rule_index %0d, expected %0d",
                                    rsp_o.rule_index, exp_rsp.rule_index));
        if (rsp_o.matched_type !== exp_rsp.matched_type)
          report_mismatch($sformatf("matched_type %h, expected %h",
                                    rsp_o.matched_type, exp_rsp.matched_type));
        if (rsp_o.status !== exp_rsp.status)
          report_mismatch($sformatf("status %b, expected %b", rsp_o.status, exp_rsp.status));
      end
    end
  end

  // bursts of requests with random gaps in between
  task automatic send_req(req_t r);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    burst_left--;
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    pending_rsp.push_back(acl_response(r));
    if (r.req_type != REQ_UNUSED) sent_cnt++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending_rsp.size() != 0);
  endtask

  function automatic req_t rand_req(logic [1:0] kind);
    req_t r;
    r.req_type   = kind;
    r.address    = $urandom();
    r.range_low  = $urandom();
    r.range_high = $urandom();
    r.type_byte  = 8'($urandom_range(0, 255));
    return r;
  endfunction

  task automatic do_lookup(logic [31:0] addr);
    req_t r;
    r = rand_req(REQ_LOOKUP);
    r.address = addr;
    send_req(r);
  endtask

  task automatic do_append(logic [31:0] lo, logic [31:0] hi, logic [7:0] ty);
    req_t r;
    r = rand_req(REQ_APPEND);
    r.range_low  = lo;
    r.range_high = hi;
    r.type_byte  = ty;
    send_req(r);
  endtask

  task automatic append_random_rule();
    logic [31:0] lo;
    logic [31:0] hi;
    logic [7:0]  a;
    logic [7:0]  b;
    for (int k = 0; k < OCTETS; k++) begin
      a = 8'($urandom_range(0, 255));
      b = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 9)) inside
        [0:2]: begin
          lo[8*k +: 8] = 8'h00;
          hi[8*k +: 8] = 8'hff;
        end
        3: begin
          lo[8*k +: 8] = (a > b) ? a : b;
          hi[8*k +: 8] = (a > b) ? b : a;
        end
        4: begin
          lo[8*k +: 8] = a;
          hi[8*k +: 8] = a;
        end
        default: begin
          lo[8*k +: 8] = (a < b) ? a : b;
          hi[8*k +: 8] = (a < b) ? b : a;
        end
      endcase
    end
    do_append(lo, hi, 8'($urandom_range(0, 255)));
  endtask

  // address inside a stored rule, on its bounds or just outside them
  function automatic logic [31:0] addr_near_rule(int unsigned j);
    logic [31:0] addr;
    logic [7:0]  lo;
    logic [7:0]  hi;
    addr = $urandom();
    for (int k = 0; k < OCTETS; k++) begin
      lo = low_tab[j][8*k +: 8];
      hi = high_tab[j][8*k +: 8];
      if (lo <= hi) begin
        case ($urandom_range(0, 11))
          0: addr[8*k +: 8] = lo;
          1: addr[8*k +: 8] = hi;
          2: addr[8*k +: 8] = (lo != 8'h00) ? lo - 8'd1 : lo;
          3: addr[8*k +: 8] = (hi != 8'hff) ? hi + 8'd1 : hi;
          default: addr[8*k +: 8] = 8'($urandom_range(int'(lo), int'(hi)));
        endcase
      end
    end
    return addr;
  endfunction

  task automatic test_directed();
    do_lookup(32'h0000_0000);
    send_req(rand_req(REQ_CLEAR));
    send_req(rand_req(REQ_UNUSED));
    do_append(32'h0000_0000, 32'hffff_ffff, 8'hff);
    do_lookup(32'h0000_0000);
    do_lookup(32'hffff_ffff);
    send_req(rand_req(REQ_CLEAR));
    do_lookup(32'h0a00_0001);
    do_append(32'h0a00_0000, 32'h0a00_00ff, "D");
    do_append(32'h0a00_0005, 32'h0a00_0003, "N");
    do_append(32'h0a00_0000, 32'h0aff_ffff, "I");
    do_append(32'h8040_2010, 32'h9050_2818, 8'h00);
    do_lookup(32'h0a00_0004);
    do_lookup(32'h0a01_0004);
    do_lookup(32'h0a00_0100);
    do_lookup(32'h0b00_0004);
    do_lookup(32'h8040_2010);
    do_lookup(32'h9050_2818);
    do_lookup(32'h9050_2819);
    do_lookup(32'h7f40_2010);
    send_req(rand_req(REQ_UNUSED));
    do_lookup(32'h0a00_0004);
  endtask

  task automatic test_table_full();
    send_req(rand_req(REQ_CLEAR));
    repeat (TABLE_DEPTH + 2) append_random_rule();
    do_lookup(addr_near_rule(TABLE_DEPTH - 1));
    do_lookup($urandom());
    send_req(rand_req(REQ_CLEAR));
    do_lookup(32'hffff_ffff);
  endtask

  task automatic test_drain_pause();
    repeat (3) append_random_rule();
    wait_drained();
    repeat (4) do_lookup(addr_near_rule($urandom_range(0, rule_cnt - 1)));
    wait_drained();
    send_req(rand_req(REQ_CLEAR));
  endtask

  task automatic test_random_sessions();
    int unsigned n_rules;
    int unsigned n_lookups;
    int unsigned sel;
    while (sent_cnt < TOTAL_ITEMS) begin
      if ($urandom_range(0, 1) == 0) send_req(rand_req(REQ_CLEAR));
      n_rules = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 20) : $urandom_range(1, 6);
      repeat (n_rules) append_random_rule();
      n_lookups = $urandom_range(4, 30);
      repeat (n_lookups) begin
        sel = $urandom_range(0, 19);
        if (sel == 0) send_req(rand_req(REQ_UNUSED));
        else if (sel == 1) send_req(rand_req(REQ_APPEND));
        else if (sel == 2) send_req(rand_req(REQ_CLEAR));
        else if (sel < 6 || rule_cnt == 0) do_lookup($urandom());
        else do_lookup(addr_near_rule($urandom_range(0, rule_cnt - 1)));
      end
      if ($urandom_range(0, 7) == 0) wait_drained();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start  = 1'b0;
    req_i  = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_table_full();
    test_drain_pause();
    test_random_sessions();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
